// File: src/cbs_pkg.sv
// Shared types, constants and helpers for the cubic Bezier sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cbs_pkg;

    // Default for the largest sample count an evaluate item may request
    localparam int MAX_SAMPLES_DEF = 64;

    // Datapath widths
    localparam int COORD_W = 24;   // Q16.8 coordinates and points
    localparam int DERIV_W = 29;   // Q21.8 derivatives
    localparam int COEF_W  = 28;   // power-basis coefficients
    localparam int U_W     = 17;   // curve parameter, Q1.16, 0 .. 1.0
    localparam int SAT_W   = 40;   // width fed into the derivative clamp

    localparam logic [U_W-1:0] U_ONE = 17'h1_0000;

    // Register stages of one axis lane, issue to result
    localparam int PIPE_LAT = 8;

    // Entries of the job queue between front and back end
    localparam int Q_DEPTH = 2;

    // Derivative clamp limits
    localparam logic signed [SAT_W-1:0] SAT_HI = 40'sd268435455;
    localparam logic signed [SAT_W-1:0] SAT_LO = -40'sd268435456;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cbs_cmd_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } cbs_front_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SETUP,
        BS_RUN
    } cbs_back_state_t;

    // One job handed from the front end to the back end
    typedef struct packed {
        logic                      is_eval;
        logic [1:0]                idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [U_W-1:0]            du;
    } cbs_job_t;

    // Power-basis coefficients of one axis
    typedef struct packed {
        logic signed [COORD_W-1:0] a0;
        logic signed [COEF_W-1:0]  a1;
        logic signed [COEF_W-1:0]  a2;
        logic signed [COEF_W-1:0]  a3;
    } cbs_coef_t;

    // Clamp a derivative to the signed Q21.8 range
    function automatic logic signed [DERIV_W-1:0] sat29(input logic signed [SAT_W-1:0] v);
        logic signed [DERIV_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DERIV_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DERIV_W-1:0];
        end
        else
        begin
            r = v[DERIV_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/cbs_front.sv
// Front end: accepts items, saturates the sample count and divides out the step.
// Depends on cbs_pkg; feeds cbs_queue.
`timescale 1ns / 1ps

module cbs_front
    import cbs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      command,
    input  logic [1:0]                point_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [6:0]                sample_count,
    input  logic                      queue_full,
    output logic                      busy,
    output logic                      push,
    output cbs_job_t                  push_job,
    output logic [CNT_W-1:0]          push_count
);

    localparam int BIT_W = $clog2(U_W);

    cbs_front_state_t state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [U_W-1:0]   quo_reg, quo_next;

    logic             accept;
    logic [CNT_W-1:0] n_sat;
    logic [CNT_W:0]   rem_sh;
    logic             q_bit;

    // Take an item only while idle and the queue has room
    assign busy   = (state_reg != FS_IDLE) || queue_full;
    assign accept = start && !busy;

    // Saturate the requested count
    always_comb
    begin
        if (32'(sample_count) > 32'(MAX_SAMPLES))
        begin
            n_sat = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            n_sat = CNT_W'(sample_count);
        end
    end

    // One restoring step of 65536 / (n - 1); the dividend has only its top bit set
    always_comb
    begin
        rem_sh = {rem_reg, (bit_reg == BIT_W'(U_W - 1))};
        q_bit  = (rem_sh >= {1'b0, div_reg});
    end

    // Next state, divider and queue push
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        push       = 1'b0;

        push_job.is_eval = (command == CMD_EVAL);
        push_job.idx     = point_index;
        push_job.x       = coord_x;
        push_job.y       = coord_y;
        push_job.z       = coord_z;
        push_job.du      = '0;
        push_count       = n_sat;

        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_LOAD)
                    begin
                        push = 1'b1;
                    end
                    else if (n_sat == CNT_W'(1))
                    begin
                        push = 1'b1;
                    end
                    else if (n_sat != '0)
                    begin
                        div_next   = n_sat - CNT_W'(1);
                        count_next = n_sat;
                        bit_next   = BIT_W'(U_W - 1);
                        rem_next   = '0;
                        quo_next   = '0;
                        state_next = FS_DIV;
                    end
                end
            end

            FS_DIV:
            begin
                if (q_bit)
                begin
                    rem_next = CNT_W'(rem_sh - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = CNT_W'(rem_sh);
                end
                quo_next = {quo_reg[U_W-2:0], q_bit};
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = FS_PUSH;
                end
            end

            FS_PUSH:
            begin
                push_job.is_eval = 1'b1;
                push_job.idx     = '0;
                push_job.x       = '0;
                push_job.y       = '0;
                push_job.z       = '0;
                push_job.du      = quo_reg;
                push_count       = count_reg;
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = FS_IDLE;
                end
            end

            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider and job payload
    always_ff @(posedge clk)
    begin
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        count_reg <= count_next;
        quo_reg   <= quo_next;
    end

endmodule

// File: src/cbs_queue.sv
// Short job queue between the front end and the back end.
// Depends on cbs_pkg for its depth.
`timescale 1ns / 1ps

module cbs_queue
    import cbs_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         valid,
    output logic [W-1:0] data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [W-1:0]     entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign data    = entry_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance the pointers with wrap at the depth
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: src/cbs_axis.sv
// One axis lane: point, first and second derivative at parameter u, 8 stages.
// Depends on cbs_pkg for the coefficient type and the derivative clamp.
`timescale 1ns / 1ps

module cbs_axis
    import cbs_pkg::*;
(
    input  logic                      clk,
    input  cbs_coef_t                 coef,
    input  logic [U_W-1:0]            u_in,
    output logic signed [COORD_W-1:0] pt,
    output logic signed [DERIV_W-1:0] d1,
    output logic signed [DERIV_W-1:0] d2
);

    // Parameter carried along to the stages that multiply by it
    logic [U_W-1:0]            u_dly [5];
    // Stage 1
    logic signed [45:0]        t1_reg, t1_next;
    // Stage 2
    logic signed [47:0]        s1_reg, s1_next;
    logic signed [47:0]        s1d_reg, s1d_next;
    logic signed [DERIV_W-1:0] d2_next;
    logic signed [DERIV_W-1:0] d2_dly [7];
    // Stage 3
    logic signed [41:0]        ph_reg, ph_next, pdh_reg, pdh_next;
    logic [40:0]               pl_reg, pl_next, pdl_reg, pdl_next;
    // Stage 4
    logic signed [65:0]        p_reg, p_next, pd_reg, pd_next;
    // Stage 5
    logic signed [65:0]        m_reg, m_next;
    logic signed [DERIV_W-1:0] d1_next;
    logic signed [DERIV_W-1:0] d1_dly [4];
    // Stage 6
    logic signed [39:0]        q2_reg, q2_next;
    logic [38:0]               q1_reg, q1_next, q0_reg, q0_next;
    // Stage 7
    logic signed [39:0]        q2b_reg;
    logic [61:0]               r_reg, r_next;
    // Stage 8
    logic signed [COORD_W-1:0] pt_reg, pt_next;

    logic signed [17:0]        us_in, us2, us5;
    logic signed [47:0]        t1x, six;
    logic signed [SAT_W-1:0]   d2_sum, d1_sum;
    logic signed [40:0]        w;

    assign us_in = $signed({1'b0, u_in});
    assign us2   = $signed({1'b0, u_dly[1]});
    assign us5   = $signed({1'b0, u_dly[4]});

    // Stage 1: a3 * u
    assign t1_next = coef.a3 * us_in;

    // Stage 2: inner Horner terms for point and slope, finish the second derivative
    always_comb
    begin
        t1x      = 48'(t1_reg);
        s1_next  = (48'(coef.a2) <<< 16) + t1x;
        s1d_next = (48'(coef.a2) <<< 17) + t1x + (t1x <<< 1);
        six      = (t1x <<< 2) + (t1x <<< 1);
        d2_sum   = SAT_W'(coef.a2) + SAT_W'(coef.a2) + SAT_W'(six >>> 16);
        d2_next  = sat29(d2_sum);
    end

    // Stage 3: multiply by u in two halves of 24 bits
    assign ph_next  = $signed(s1_reg[47:24]) * us2;
    assign pl_next  = s1_reg[23:0] * u_dly[1];
    assign pdh_next = $signed(s1d_reg[47:24]) * us2;
    assign pdl_next = s1d_reg[23:0] * u_dly[1];

    // Stage 4: join the partial products
    assign p_next  = (66'(ph_reg) <<< 24) + $signed({25'd0, pl_reg});
    assign pd_next = (66'(pdh_reg) <<< 24) + $signed({25'd0, pdl_reg});

    // Stage 5: outer Horner term, finish the first derivative
    always_comb
    begin
        m_next  = (66'(coef.a1) <<< 32) + p_reg;
        d1_sum  = SAT_W'(coef.a1) + SAT_W'(pd_reg >>> 32);
        d1_next = sat29(d1_sum);
    end

    // Stage 6: last multiply by u in three slices of 22 bits
    assign q2_next = $signed(m_reg[65:44]) * us5;
    assign q1_next = m_reg[43:22] * u_dly[4];
    assign q0_next = m_reg[21:0] * u_dly[4];

    // Stage 7: join the two low slices
    assign r_next = 62'({q1_reg, 22'd0}) + 62'(q0_reg);

    // Stage 8: drop 48 fraction bits (floor) and add the constant term
    always_comb
    begin
        w       = 41'(q2b_reg) + $signed({23'd0, r_reg[61:44]});
        pt_next = coef.a0 + $signed(w[27:4]);
    end

    // Advance all stages
    always_ff @(posedge clk)
    begin
        u_dly[0] <= u_in;
        for (int i = 1; i < 5; i++)
        begin
            u_dly[i] <= u_dly[i-1];
        end
        t1_reg    <= t1_next;
        s1_reg    <= s1_next;
        s1d_reg   <= s1d_next;
        d2_dly[0] <= d2_next;
        for (int i = 1; i < 7; i++)
        begin
            d2_dly[i] <= d2_dly[i-1];
        end
        ph_reg    <= ph_next;
        pl_reg    <= pl_next;
        pdh_reg   <= pdh_next;
        pdl_reg   <= pdl_next;
        p_reg     <= p_next;
        pd_reg    <= pd_next;
        m_reg     <= m_next;
        d1_dly[0] <= d1_next;
        for (int i = 1; i < 4; i++)
        begin
            d1_dly[i] <= d1_dly[i-1];
        end
        q2_reg    <= q2_next;
        q1_reg    <= q1_next;
        q0_reg    <= q0_next;
        q2b_reg   <= q2_reg;
        r_reg     <= r_next;
        pt_reg    <= pt_next;
    end

    assign pt = pt_reg;
    assign d1 = d1_dly[3];
    assign d2 = d2_dly[6];

endmodule

// File: src/cbs_back.sv
// Back end: control points, coefficient setup, sample sequencer and three axis lanes.
// Depends on cbs_pkg and cbs_axis; takes jobs from cbs_queue.
`timescale 1ns / 1ps

module cbs_back
    import cbs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  cbs_job_t                  job,
    input  logic [CNT_W-1:0]          job_count,
    output logic                      pop,
    output logic                      result_strobe,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic signed [DERIV_W-1:0] tangent_x,
    output logic signed [DERIV_W-1:0] tangent_y,
    output logic signed [DERIV_W-1:0] tangent_z,
    output logic signed [DERIV_W-1:0] second_x,
    output logic signed [DERIV_W-1:0] second_y,
    output logic signed [DERIV_W-1:0] second_z,
    output logic                      last_sample
);

    cbs_back_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] cp_reg [4][3];
    cbs_coef_t                 coef_reg [3];
    cbs_coef_t                 coef_new [3];
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [U_W-1:0]            du_reg, du_next;
    logic [U_W-1:0]            acc_reg, acc_next;
    logic [PIPE_LAT-1:0]       vld_reg;
    logic [PIPE_LAT-1:0]       last_reg;

    logic                      cp_we;
    logic                      coef_we;
    logic                      issue;
    logic                      issue_last;
    logic [U_W-1:0]            issue_u;

    logic signed [COORD_W-1:0] pt_w [3];
    logic signed [DERIV_W-1:0] d1_w [3];
    logic signed [DERIV_W-1:0] d2_w [3];

    // Power-basis coefficients from the current control points
    always_comb
    begin
        logic signed [COEF_W-1:0] p0, p1, p2, p3, e, dd;
        for (int k = 0; k < 3; k++)
        begin
            p0 = COEF_W'(cp_reg[0][k]);
            p1 = COEF_W'(cp_reg[1][k]);
            p2 = COEF_W'(cp_reg[2][k]);
            p3 = COEF_W'(cp_reg[3][k]);
            dd = p1 - p0;
            e  = p0 - (p1 <<< 1) + p2;
            coef_new[k].a0 = cp_reg[0][k];
            coef_new[k].a1 = dd + (dd <<< 1);
            coef_new[k].a2 = e + (e <<< 1);
            coef_new[k].a3 = p3 - p2 - (p2 <<< 1) + p1 + (p1 <<< 1) - p0;
        end
    end

    // Sequencer: apply loads, set up coefficients, issue one sample per cycle
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        du_next    = du_reg;
        acc_next   = acc_reg;
        pop        = 1'b0;
        cp_we      = 1'b0;
        coef_we    = 1'b0;
        issue      = 1'b0;
        issue_last = (idx_reg == n_reg - CNT_W'(1));
        issue_u    = issue_last ? U_ONE : acc_reg;

        case (state_reg)
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    if (job.is_eval)
                    begin
                        n_next     = job_count;
                        du_next    = job.du;
                        state_next = BS_SETUP;
                    end
                    else
                    begin
                        cp_we = 1'b1;
                    end
                end
            end

            BS_SETUP:
            begin
                // Wait for the lanes to drain before the coefficients change
                if (vld_reg == '0)
                begin
                    coef_we    = 1'b1;
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = BS_RUN;
                end
            end

            BS_RUN:
            begin
                issue    = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                acc_next = acc_reg + du_reg;
                if (issue_last)
                begin
                    state_next = BS_IDLE;
                end
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Control state, control points and the sample markers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            vld_reg   <= '0;
            last_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cp_reg[i][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= {vld_reg[PIPE_LAT-2:0], issue};
            last_reg  <= {last_reg[PIPE_LAT-2:0], issue && issue_last};
            if (cp_we)
            begin
                cp_reg[job.idx][0] <= job.x;
                cp_reg[job.idx][1] <= job.y;
                cp_reg[job.idx][2] <= job.z;
            end
        end
    end

    // Run parameters and coefficients
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        idx_reg <= idx_next;
        du_reg  <= du_next;
        acc_reg <= acc_next;
        if (coef_we)
        begin
            for (int k = 0; k < 3; k++)
            begin
                coef_reg[k] <= coef_new[k];
            end
        end
    end

    // One lane per axis
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        cbs_axis u_axis (
            .clk  (clk),
            .coef (coef_reg[g]),
            .u_in (issue_u),
            .pt   (pt_w[g]),
            .d1   (d1_w[g]),
            .d2   (d2_w[g])
        );
    end

    assign result_strobe = vld_reg[PIPE_LAT-1];
    assign last_sample   = last_reg[PIPE_LAT-1];
    assign point_x       = pt_w[0];
    assign point_y       = pt_w[1];
    assign point_z       = pt_w[2];
    assign tangent_x     = d1_w[0];
    assign tangent_y     = d1_w[1];
    assign tangent_z     = d1_w[2];
    assign second_x      = d2_w[0];
    assign second_y      = d2_w[1];
    assign second_z      = d2_w[2];

endmodule

// File: src/cubic_bezier_sampler_core.sv
// Cubic Bezier sampler: point, tangent and second derivative at n uniform parameters.
// A load passes the queue register before it reaches the control points; the first sample
// of an evaluate passes the step divider, the queue, setup and the 8-stage lanes; a count of
// one skips the divider. Samples leave at one per cycle within a run; an evaluate holds the
// sequencer through setup, which waits for the lanes to drain, and through its run.
// Reset: asynchronous, active low; control points clear to zero. Results cannot stall.
`timescale 1ns / 1ps

module cubic_bezier_sampler_core
    import cbs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [1:0]                point_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [6:0]                sample_count,
    output logic                      result_strobe,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic signed [DERIV_W-1:0] tangent_x,
    output logic signed [DERIV_W-1:0] tangent_y,
    output logic signed [DERIV_W-1:0] tangent_z,
    output logic signed [DERIV_W-1:0] second_x,
    output logic signed [DERIV_W-1:0] second_y,
    output logic signed [DERIV_W-1:0] second_z,
    output logic                      last_sample
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int JOB_W = $bits(cbs_job_t);
    localparam int Q_W   = JOB_W + CNT_W;

    logic             push;
    cbs_job_t         push_job;
    logic [CNT_W-1:0] push_count;
    logic             queue_full;
    logic             pop;
    logic             q_valid;
    logic [Q_W-1:0]   q_data;
    cbs_job_t         q_job;
    logic [CNT_W-1:0] q_count;

    // Accept and classify items, divide out the step
    cbs_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .point_index  (point_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .sample_count (sample_count),
        .queue_full   (queue_full),
        .busy         (busy),
        .push         (push),
        .push_job     (push_job),
        .push_count   (push_count)
    );

    // Decouple front and back end
    cbs_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_count, push_job}),
        .pop       (pop),
        .full      (queue_full),
        .valid     (q_valid),
        .data      (q_data)
    );

    assign q_job   = q_data[JOB_W-1:0];
    assign q_count = q_data[Q_W-1:JOB_W];

    // Carry out loads and sample runs
    cbs_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_valid),
        .job           (q_job),
        .job_count     (q_count),
        .pop           (pop),
        .result_strobe (result_strobe),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .tangent_x     (tangent_x),
        .tangent_y     (tangent_y),
        .tangent_z     (tangent_z),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_z      (second_z),
        .last_sample   (last_sample)
    );

endmodule

// File: test/bezier_sample_monitor.sv
// Passive monitor for the cubic Bezier sampler: predicts every sample and checks each strobe.
// Depends on cbs_pkg for widths and the command encoding; holds its own copy of the points.
`timescale 1ns / 1ps

module bezier_sample_monitor
    import cbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      command,
    input  logic [1:0]                point_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [6:0]                sample_count,
    input  logic                      result_strobe,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic signed [DERIV_W-1:0] tangent_x,
    input  logic signed [DERIV_W-1:0] tangent_y,
    input  logic signed [DERIV_W-1:0] tangent_z,
    input  logic signed [DERIV_W-1:0] second_x,
    input  logic signed [DERIV_W-1:0] second_y,
    input  logic signed [DERIV_W-1:0] second_z,
    input  logic                      last_sample,
    output int                        errors,
    output int                        outstanding,
    output int                        loads_seen,
    output int                        evals_seen,
    output int                        samples_checked
);

    localparam int WIDE = 96;
    localparam logic signed [WIDE-1:0] DERIV_MAX = WIDE'(268435455);
    localparam logic signed [WIDE-1:0] DERIV_MIN = WIDE'(-268435456);

    // Point, first and second derivative of one axis
    typedef struct packed {
        logic signed [COORD_W-1:0] pt;
        logic signed [DERIV_W-1:0] d1;
        logic signed [DERIV_W-1:0] d2;
    } axis_sample_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [DERIV_W-1:0] tx;
        logic signed [DERIV_W-1:0] ty;
        logic signed [DERIV_W-1:0] tz;
        logic signed [DERIV_W-1:0] sx;
        logic signed [DERIV_W-1:0] sy;
        logic signed [DERIV_W-1:0] sz;
        logic                      last;
    } curve_sample_t;

    logic signed [COORD_W-1:0] ctrl_pts [4][3];
    curve_sample_t             pending_samples [$];
    int                        mismatches;

    function automatic logic signed [DERIV_W-1:0] clamp_deriv(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] c;
        c = (v > DERIV_MAX) ? DERIV_MAX : ((v < DERIV_MIN) ? DERIV_MIN : v);
        return c[DERIV_W-1:0];
    endfunction

    // Power-basis evaluation, kept exact in 96 bits; arithmetic shifts floor the result
    function automatic axis_sample_t bezier_axis(input int axis, input logic [U_W-1:0] u_q16);
        logic signed [WIDE-1:0] p0, p1, p2, p3, u, b1, b2, b3, m, acc;
        axis_sample_t s;
        p0 = WIDE'(ctrl_pts[0][axis]);
        p1 = WIDE'(ctrl_pts[1][axis]);
        p2 = WIDE'(ctrl_pts[2][axis]);
        p3 = WIDE'(ctrl_pts[3][axis]);
        u  = WIDE'(u_q16);
        b1 = 3 * (p1 - p0);
        b2 = 3 * (p0 - 2 * p1 + p2);
        b3 = p3 - 3 * p2 + 3 * p1 - p0;
        // B(u) = p0 + u*(b1 + b2 u + b3 u^2), u in Q1.16
        m    = (b1 <<< 32) + ((b2 * u) <<< 16) + b3 * u * u;
        acc  = p0 + ((m * u) >>> 48);
        s.pt = acc[COORD_W-1:0];
        acc  = (b1 <<< 32) + ((2 * b2 * u) <<< 16) + 3 * b3 * u * u;
        s.d1 = clamp_deriv(acc >>> 32);
        acc  = ((2 * b2) <<< 16) + 6 * b3 * u;
        s.d2 = clamp_deriv(acc >>> 16);
        return s;
    endfunction

    // Queue every sample that one evaluate item should produce
    function automatic void queue_curve_samples(input logic [6:0] count);
        int n, du;
        logic [U_W-1:0] u;
        axis_sample_t ax, ay, az;
        curve_sample_t cs;
        n  = (count > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : int'(count);
        du = (n > 1) ? 65536 / (n - 1) : 0;
        for (int i = 0; i < n; i++)
        begin
            u  = (i == n - 1) ? U_ONE : U_W'(i * du);
            ax = bezier_axis(0, u);
            ay = bezier_axis(1, u);
            az = bezier_axis(2, u);
            cs = '{ax.pt, ay.pt, az.pt, ax.d1, ay.d1, az.d1, ax.d2, ay.d2, az.d2,
                   (i == n - 1)};
            pending_samples.push_back(cs);
        end
    endfunction

    function automatic void check_field(input string what, input longint want,
                                        input longint got);
        if (want != got)
        begin
            errors++;
            if (mismatches < 10)
            begin
                $display("[%0t] sample %0d: %s expected %0d, got %0d",
                         $realtime, samples_checked, what, want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_sample_t want;
        if (!rst_n)
        begin
            foreach (ctrl_pts[i, j])
            begin
                ctrl_pts[i][j] = '0;
            end
            pending_samples.delete();
            errors          = 0;
            mismatches      = 0;
            loads_seen      = 0;
            evals_seen      = 0;
            samples_checked = 0;
            outstanding    <= 0;
        end
        else
        begin
            // Compare a strobed sample with the oldest prediction
            if (result_strobe)
            begin
                if (pending_samples.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                    begin
                        $display("[%0t] unexpected sample: point %0d %0d %0d", $realtime,
                                 point_x, point_y, point_z);
                    end
                    mismatches++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    check_field("point_x",     longint'(want.px),   longint'(point_x));
                    check_field("point_y",     longint'(want.py),   longint'(point_y));
                    check_field("point_z",     longint'(want.pz),   longint'(point_z));
                    check_field("tangent_x",   longint'(want.tx),   longint'(tangent_x));
                    check_field("tangent_y",   longint'(want.ty),   longint'(tangent_y));
                    check_field("tangent_z",   longint'(want.tz),   longint'(tangent_z));
                    check_field("second_x",    longint'(want.sx),   longint'(second_x));
                    check_field("second_y",    longint'(want.sy),   longint'(second_y));
                    check_field("second_z",    longint'(want.sz),   longint'(second_z));
                    check_field("last_sample", longint'(want.last), longint'(last_sample));
                    samples_checked++;
                end
            end

            // Apply an accepted item to the predicted state
            if (start && !busy)
            begin
                if (command == CMD_EVAL)
                begin
                    evals_seen++;
                    queue_curve_samples(sample_count);
                end
                else
                begin
                    loads_seen++;
                    ctrl_pts[point_index][0] = coord_x;
                    ctrl_pts[point_index][1] = coord_y;
                    ctrl_pts[point_index][2] = coord_z;
                end
            end
            outstanding <= pending_samples.size();
        end
    end

endmodule

// File: test/tb.sv
// Top of the cubic Bezier sampler testbench: clock, reset, item stimulus and verdict.
// Depends on cbs_pkg, cubic_bezier_sampler_core and bezier_sample_monitor.
`timescale 1ns / 1ps

module tb;
    import cbs_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      command;
    logic [1:0]                point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [6:0]                sample_count;
    logic                      result_strobe;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [DERIV_W-1:0] tangent_x;
    logic signed [DERIV_W-1:0] tangent_y;
    logic signed [DERIV_W-1:0] tangent_z;
    logic signed [DERIV_W-1:0] second_x;
    logic signed [DERIV_W-1:0] second_y;
    logic signed [DERIV_W-1:0] second_z;
    logic                      last_sample;
    int                        errors;
    int                        outstanding;
    int                        loads_seen;
    int                        evals_seen;
    int                        samples_checked;

    int items_sent;
    int drain_cycles;

    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = -24'sh800000;

    cubic_bezier_sampler_core dut (.*);

    bezier_sample_monitor sample_mon (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Present one item, sometimes after a random idle gap, and hold it until accepted
    task automatic send_item(input cbs_cmd_t cmd, input logic [1:0] idx,
                             input logic [23:0] x, input logic [23:0] y,
                             input logic [23:0] z, input logic [6:0] count);
        bit quiet;
        quiet = (items_sent >= 200 && items_sent < 300);
        if (!quiet && $urandom_range(0, 99) < 33)
        begin
            start        <= 1'b0;
            command      <= 1'($urandom_range(0, 1));
            point_index  <= 2'($urandom_range(0, 3));
            coord_x      <= 24'($urandom());
            coord_y      <= 24'($urandom());
            coord_z      <= 24'($urandom());
            sample_count <= 7'($urandom_range(0, 127));
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(5, 60)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        start        <= 1'b1;
        command      <= cmd;
        point_index  <= idx;
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        sample_count <= count;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Ignored fields carry random values
    task automatic load_point(input logic [1:0] idx, input logic [23:0] x,
                              input logic [23:0] y, input logic [23:0] z);
        send_item(CMD_LOAD, idx, x, y, z, 7'($urandom_range(0, 127)));
    endtask

    task automatic evaluate(input logic [6:0] count);
        send_item(CMD_EVAL, 2'($urandom_range(0, 3)), 24'($urandom()), 24'($urandom()),
                  24'($urandom()), count);
    endtask

    function automatic logic [23:0] pick_coord();
        int v;
        case ($urandom_range(0, 5))
            0:
            begin
                return $urandom_range(0, 1) ? C_MAX : C_MIN;
            end
            1, 2:
            begin
                v = $urandom_range(0, 4095);
                return 24'(v - 2048);
            end
            default:
            begin
                return 24'($urandom());
            end
        endcase
    endfunction

    // Mostly short runs, some long ones, a few counts above the sample limit
    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 7'd0;
        end
        else if (r < 10)
        begin
            return 7'd1;
        end
        else if (r < 70)
        begin
            return 7'($urandom_range(2, 12));
        end
        else if (r < 90)
        begin
            return 7'($urandom_range(13, 64));
        end
        return 7'($urandom_range(65, 127));
    endfunction

    initial
    begin
        items_sent   = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= CMD_LOAD;
        point_index  <= '0;
        coord_x      <= '0;
        coord_y      <= '0;
        coord_z      <= '0;
        sample_count <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: curve from the reset points, then extreme control points
        evaluate(3);
        load_point(0, C_MAX, C_MIN, C_MAX);
        load_point(1, C_MIN, C_MAX, C_MIN);
        load_point(2, C_MIN, C_MAX, C_MAX);
        load_point(3, C_MAX, C_MIN, C_MIN);
        evaluate(1);
        evaluate(2);
        evaluate(0);
        evaluate(64);
        evaluate(127);
        // Zigzag polygon, a count just over the limit and two short counts
        load_point(0, C_MIN, C_MIN, C_MAX);
        load_point(1, C_MAX, C_MAX, C_MIN);
        load_point(2, C_MIN, C_MIN, C_MAX);
        load_point(3, C_MAX, C_MAX, C_MIN);
        evaluate(65);
        evaluate(3);
        evaluate(5);
        // Small mixed-sign values to exercise rounding toward minus infinity
        load_point(0, -24'sd1, 24'sd3, -24'sd255);
        load_point(1, -24'sd3, -24'sd7, 24'sd129);
        load_point(2, 24'sd5, -24'sd1, -24'sd2);
        load_point(3, -24'sd7, 24'sd11, 24'sd1);
        evaluate(7);
        evaluate(17);
        load_point(2, 24'h555555, 24'hAAAAAA, 24'h555555);
        evaluate(4);

        // Random: mostly reload some points then sample, sometimes lone items
        while (items_sent < 420)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    load_point(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                               pick_coord());
                end
                evaluate(pick_count());
            end
            else if ($urandom_range(0, 1))
            begin
                evaluate(pick_count());
            end
            else
            begin
                load_point(2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                           pick_coord());
            end
        end
        start <= 1'b0;

        // Drain the remaining samples, then watch for strays
        @(posedge clk);
        drain_cycles = 0;
        while (outstanding != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (60) @(posedge clk);

        $display("Run covered %0d point loads and %0d curve evaluations.",
                 loads_seen, evals_seen);
        $display("%0d samples compared, %0d mismatches, %0d samples never arrived.",
                 samples_checked, errors, outstanding);
        if (errors == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
